### sv/abu_pkg.sv
// Shared types, widths and constants of the bounded-rate parameter update.
// No dependencies; compiled first.
`default_nettype none
package abu_pkg;

   localparam int SLOTS       = 4096;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int DATA_W      = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 31;
   localparam int ROOT_W      = 28;
   localparam int RATE_W      = 31;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int NUM_W       = RATE_W + 24;
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [1:0]  EPS_Q   = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BETA_ONE    = 3'd0,
      CSR_BETA_TWO    = 3'd1,
      CSR_STEP_SIZE   = 3'd2,
      CSR_LOWER_BOUND = 3'd3,
      CSR_UPPER_BOUND = 3'd4
   } csr_index_type;

   // fields that ride alongside the rate computation
   typedef struct packed {
      logic signed [DATA_W-1:0] m;
      logic signed [DATA_W-1:0] p;
      logic                     last;
   } side_type;

endpackage
`default_nettype wire

### sv/abu_req_if.sv
// Request channel: slot, gradient, parameter and flags with valid/ready.
// Depends on abu_pkg.
`default_nettype none
interface abu_req_if
   import abu_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [SLOT_W-1:0]        slot_address;
   logic signed [DATA_W-1:0] gradient;
   logic signed [DATA_W-1:0] param_value;
   logic                     first_use;
   logic                     last_in;

   modport source (output valid, slot_address, gradient, param_value, first_use, last_in,
                   input ready);
   modport sink   (input valid, slot_address, gradient, param_value, first_use, last_in,
                   output ready);
endinterface
`default_nettype wire

### sv/abu_rsp_if.sv
// Response channel: updated parameter and layer-end flag with valid/ready.
// Depends on abu_pkg.
`default_nettype none
interface abu_rsp_if
   import abu_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] new_param;
   logic                     last_out;

   modport source (output valid, new_param, last_out, input ready);
   modport sink   (input valid, new_param, last_out, output ready);
endinterface
`default_nettype wire

### sv/amsbound_param_update_unit.sv
// Bounded-rate optimiser update, one element per transfer, Q8.24 fixed point.
// Depends on abu_pkg, abu_req_if, abu_rsp_if, abu_sqrt and abu_div.
//
// Usage: req carries slot_address, gradient, param_value, first_use and
// last_in; rsp returns new_param and last_out, one response per request, in
// order. Software writes the decays, step size and rate bounds through the
// csr_ port while no element is in flight.
// The moments live in one 4096-entry memory, 96 bits a word, read as the request
// moves from stage Z into stage A and written back as it leaves stage A; a
// bypass from the write-back register covers back-to-back hits on the same slot.
// A request passes stages Z, A and B for the moment read-modify-write, 28
// square-root stages (one root bit per stage), 31 divider stages (one quotient
// bit per stage) and three registers for the clamp, multiply and final
// subtract. Throughput is one element per cycle while the output register is empty.
// Reset clears the pipeline valids and loads the default configuration; the
// moment memory is not cleared, so the first touch of a slot must set
// first_use. When rsp stalls, an output register catches the waiting response;
// from the next cycle the whole pipeline holds and req.ready falls.
`default_nettype none
module amsbound_param_update_unit
   import abu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   abu_req_if.sink                    req,
   abu_rsp_if.source                  rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [15:0]       beta_one_ff, beta_two_ff;
   logic [RATE_W-1:0] step_ff, lower_ff, upper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_one_ff <= 16'd58982;
         beta_two_ff <= 16'd65470;
         step_ff     <= RATE_W'(16777);
         lower_ff    <= '0;
         upper_ff    <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BETA_ONE:    beta_one_ff <= csr_wdata[15:0];
            CSR_BETA_TWO:    beta_two_ff <= csr_wdata[15:0];
            CSR_STEP_SIZE:   step_ff     <= csr_wdata;
            CSR_LOWER_BOUND: lower_ff    <= csr_wdata;
            CSR_UPPER_BOUND: upper_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   logic out_valid_ff;
   logic skid_valid_ff;
   assign adv       = !skid_valid_ff;
   assign req.ready = adv;

   // stage Z: registered request, gradient squared
   logic                     z_valid_ff;
   logic [SLOT_W-1:0]        z_slot_ff;
   logic signed [DATA_W-1:0] z_g_ff, z_p_ff;
   logic                     z_first_ff, z_last_ff;
   logic [DATA_W-1:0]        z_abs_g;

   always_ff @(posedge clock) begin
      if (reset) begin
         z_valid_ff <= 1'b0;
      end else if (adv) begin
         z_valid_ff <= req.valid;
      end
      if (adv) begin
         z_slot_ff  <= req.slot_address;
         z_g_ff     <= req.gradient;
         z_p_ff     <= req.param_value;
         z_first_ff <= req.first_use;
         z_last_ff  <= req.last_in;
      end
   end

   assign z_abs_g = z_g_ff[DATA_W-1] ? DATA_W'(-z_g_ff) : z_g_ff;

   // stage A: moment update from memory or bypass
   logic                     a_valid_ff;
   logic [SLOT_W-1:0]        a_slot_ff;
   logic signed [DATA_W-1:0] a_g_ff, a_p_ff;
   logic                     a_first_ff, a_last_ff, a_hit_ff;
   logic [38:0]              a_g2_ff;
   logic [DATA_W-1:0]        rd_m_ff, rd_v_ff, rd_vh_ff;
   logic [63:0]              g_sq;

   // word: first moment, second moment, maximum second moment
   logic [3*DATA_W-1:0] mom_mem [SLOTS];

   // stage B: write-back register, also the bypass source
   logic                     b_valid_ff;
   logic signed [DATA_W-1:0] b_m_ff, b_p_ff;
   logic [DATA_W-1:0]        b_v_ff, b_vh_ff;
   logic                     b_last_ff;

   assign g_sq = z_abs_g * z_abs_g;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= z_valid_ff;
      end
      if (adv) begin
         a_slot_ff  <= z_slot_ff;
         a_g_ff     <= z_g_ff;
         a_p_ff     <= z_p_ff;
         a_first_ff <= z_first_ff;
         a_last_ff  <= z_last_ff;
         a_g2_ff    <= 39'((g_sq + 64'(1 << 23)) >> 24);
         // A writes this slot at the same edge, so the read sees stale data
         a_hit_ff   <= a_valid_ff && (a_slot_ff == z_slot_ff);
         {rd_m_ff, rd_v_ff, rd_vh_ff} <= mom_mem[z_slot_ff];
      end
   end

   logic signed [DATA_W-1:0] m_old;
   logic [DATA_W-1:0]        v_old, vh_old, v_new, vh_new;
   logic signed [DATA_W-1:0] m_new;
   logic [16:0]              omb1, omb2;
   logic signed [49:0]       msum, mrnd;
   logic [56:0]              vsum;
   logic [40:0]              vrnd;

   always_comb begin
      m_old  = a_first_ff ? '0 : (a_hit_ff ? b_m_ff  : rd_m_ff);
      v_old  = a_first_ff ? '0 : (a_hit_ff ? b_v_ff  : rd_v_ff);
      vh_old = a_first_ff ? '0 : (a_hit_ff ? b_vh_ff : rd_vh_ff);
      omb1   = ONE_Q16 - {1'b0, beta_one_ff};
      omb2   = ONE_Q16 - {1'b0, beta_two_ff};
      msum   = $signed({1'b0, beta_one_ff}) * m_old + $signed({1'b0, omb1}) * a_g_ff;
      mrnd   = (msum + 50'sd32768) >>> 16;
      if (mrnd > 50'sd2147483647) begin
         m_new = 32'sh7FFFFFFF;
      end else if (mrnd < -50'sd2147483648) begin
         m_new = 32'sh80000000;
      end else begin
         m_new = mrnd[DATA_W-1:0];
      end
      vsum   = 57'(beta_two_ff) * 57'(v_old) + 57'(omb2) * 57'(a_g2_ff);
      vrnd   = 41'((vsum + 57'd32768) >> 16);
      v_new  = (|vrnd[40:32]) ? '1 : vrnd[DATA_W-1:0];
      vh_new = (a_first_ff || v_new > vh_old) ? v_new : vh_old;
   end

   always_ff @(posedge clock) begin
      if (adv && a_valid_ff) begin
         mom_mem[a_slot_ff] <= {m_new, v_new, vh_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv && a_valid_ff) begin
         b_m_ff    <= m_new;
         b_v_ff    <= v_new;
         b_vh_ff   <= vh_new;
         b_p_ff    <= a_p_ff;
         b_last_ff <= a_last_ff;
      end
   end

   side_type          b_side, sq_side, dv_side;
   logic              sq_valid, dv_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [RATE_W-1:0] dv_rate;

   assign b_side = '{m: b_m_ff, p: b_p_ff, last: b_last_ff};

   abu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (b_valid_ff),
      .vhat      (b_vh_ff),
      .in_side   (b_side),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   abu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .root      (sq_root),
      .step_size (step_ff),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .rate      (dv_rate),
      .out_side  (dv_side)
   );

   // clamp, multiply, subtract
   logic              c_valid_ff, x_valid_ff;
   logic [RATE_W-1:0] c_rate_ff, c_rate_in;
   side_type          c_side_ff, x_side_ff;
   logic signed [62:0] x_prod_ff;
   logic signed [38:0] delta;
   logic signed [40:0] np_wide;
   logic signed [DATA_W-1:0] np_sat, np_ff;
   logic              last_ff;
   logic signed [DATA_W-1:0] skid_np_ff;
   logic              skid_last_ff;

   always_comb begin
      c_rate_in = dv_rate;
      if (c_rate_in < lower_ff) c_rate_in = lower_ff;
      if (c_rate_in > upper_ff) c_rate_in = upper_ff;
      delta   = 39'((x_prod_ff + 63'sd8388608) >>> 24);
      np_wide = 41'(x_side_ff.p) - 41'(delta);
      if (np_wide > 41'sd2147483647) begin
         np_sat = 32'sh7FFFFFFF;
      end else if (np_wide < -41'sd2147483648) begin
         np_sat = 32'sh80000000;
      end else begin
         np_sat = np_wide[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         x_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff   <= dv_valid;
         x_valid_ff   <= c_valid_ff;
         out_valid_ff <= x_valid_ff;
      end
      if (adv) begin
         c_rate_ff <= c_rate_in;
         c_side_ff <= dv_side;
         x_prod_ff <= c_side_ff.m * $signed({1'b0, c_rate_ff});
         x_side_ff <= c_side_ff;
         np_ff     <= np_sat;
         last_ff   <= x_side_ff.last;
      end
   end

   // hold a response that was not taken while the pipeline advanced
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         skid_valid_ff <= !rsp.ready;
      end else begin
         skid_valid_ff <= out_valid_ff && !rsp.ready;
      end
      if (!skid_valid_ff) begin
         skid_np_ff   <= np_ff;
         skid_last_ff <= last_ff;
      end
   end

   assign rsp.valid     = skid_valid_ff || out_valid_ff;
   assign rsp.new_param = skid_valid_ff ? skid_np_ff : np_ff;
   assign rsp.last_out  = skid_valid_ff ? skid_last_ff : last_ff;

endmodule
`default_nettype wire

### sv/abu_sqrt.sv
// Pipelined integer square root of vhat * 2^24, one root bit per stage.
// Depends on abu_pkg.
`default_nettype none
module abu_sqrt
   import abu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [DATA_W-1:0] vhat,
   input  wire side_type          in_side,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      root,
   output side_type               out_side
);

   logic [RAD_W-1:0]  rem_ff   [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff  [ROOT_W+1];
   side_type          side_ff  [ROOT_W+1];
   logic              valid_ff [ROOT_W+1];

   always_comb begin
      rem_ff[0]   = {vhat, 24'd0};
      root_ff[0]  = '0;
      side_ff[0]  = in_side;
      valid_ff[0] = in_valid;
   end

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      localparam int K = ROOT_W - 1 - i;
      logic [RAD_W+1:0]  trial;
      logic [RAD_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         trial = ({{(RAD_W+2-ROOT_W){1'b0}}, root_ff[i]} << (K + 1))
               + ((RAD_W+2)'(1) << (2 * K));
         rem_in  = rem_ff[i];
         root_in = root_ff[i];
         if ({2'b00, rem_ff[i]} >= trial) begin
            rem_in  = rem_ff[i] - trial[RAD_W-1:0];
            root_in = root_ff[i] | (ROOT_W'(1) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (en) begin
            rem_ff[i+1]  <= rem_in;
            root_ff[i+1] <= root_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign root      = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule
`default_nettype wire

### sv/abu_div.sv
// Pipelined restoring divider: step_size * 2^24 / (root + eps), one quotient
// bit per stage, saturating to the largest rate. Depends on abu_pkg.
`default_nettype none
module abu_div
   import abu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [ROOT_W-1:0] root,
   input  wire logic [RATE_W-1:0] step_size,
   input  wire side_type          in_side,
   output logic                   out_valid,
   output logic [RATE_W-1:0]      rate,
   output side_type               out_side
);

   localparam int CMP_W = NUM_W + RATE_W;

   logic [ROOT_W:0]   den_ff   [RATE_W+1];
   logic [NUM_W-1:0]  rem_ff   [RATE_W+1];
   logic [RATE_W-1:0] quo_ff   [RATE_W+1];
   logic              ovf_ff   [RATE_W+1];
   side_type          side_ff  [RATE_W+1];
   logic              valid_ff [RATE_W+1];

   always_comb begin
      den_ff[0]   = {1'b0, root} + (ROOT_W+1)'(EPS_Q);
      rem_ff[0]   = {step_size, 24'd0};
      quo_ff[0]   = '0;
      // quotient reaches 2^31 exactly when step_size >= den * 2^7
      ovf_ff[0]   = {12'd0, step_size} >= {7'd0, den_ff[0], 7'd0};
      side_ff[0]  = in_side;
      valid_ff[0] = in_valid;
   end

   for (genvar i = 0; i < RATE_W; i++) begin : g_stage
      localparam int K = RATE_W - 1 - i;
      logic [CMP_W-1:0]  shifted;
      logic [NUM_W-1:0]  rem_in;
      logic [RATE_W-1:0] quo_in;

      always_comb begin
         shifted = {{(CMP_W-ROOT_W-1){1'b0}}, den_ff[i]} << K;
         rem_in  = rem_ff[i];
         quo_in  = quo_ff[i];
         if ({{RATE_W{1'b0}}, rem_ff[i]} >= shifted) begin
            rem_in = rem_ff[i] - shifted[NUM_W-1:0];
            quo_in = quo_ff[i] | (RATE_W'(1) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (en) begin
            den_ff[i+1]  <= den_ff[i];
            rem_ff[i+1]  <= rem_in;
            quo_ff[i+1]  <= quo_in;
            ovf_ff[i+1]  <= ovf_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[RATE_W];
   assign rate      = ovf_ff[RATE_W] ? '1 : quo_ff[RATE_W];
   assign out_side  = side_ff[RATE_W];

endmodule
`default_nettype wire
